@@ sv/binary_neighbourhood_lut_filter_unit_assert.svh @@
// Assertion macros shared by the filter RTL.
`ifndef BINARY_NEIGHBOURHOOD_LUT_FILTER_UNIT_ASSERT_SVH
`define BINARY_NEIGHBOURHOOD_LUT_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BLNF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("blnf assertion failed");
`define BLNF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blnf assertion failed");
`define BLNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blnf assertion failed");
`else
`define BLNF_ASSERT(label, clk, rst, prop)
`define BLNF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BLNF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/blnf_pkg.sv @@
// Types and constants of the binary 3x3 neighborhood table filter.
package blnf_pkg;

   localparam int LUT_WORDS  = 8;
   localparam int WORD_W     = 64;
   localparam int LUT_SIZE   = LUT_WORDS * WORD_W;
   localparam int IDX_W      = $clog2(LUT_SIZE);
   localparam int MAX_WIDTH  = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int NUM_RES    = 4;
   localparam int RES_IDX_W  = $clog2(NUM_RES);
   localparam int RES_CNT_W  = RES_IDX_W + 1;

   // window bits that survive a column shift (left and middle columns)
   localparam logic [IDX_W-1:0] KEEP_MASK = 9'h1B6;

   typedef logic [LUT_SIZE-1:0] lut_type;

   typedef struct packed {
      logic             pixel_out;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             last;
   } res_type;

   function automatic logic tbl_bit(lut_type lut, logic [IDX_W-1:0] idx);
      return lut[idx];
   endfunction

   // shift the 3x3 window one column left and insert a new right column
   function automatic logic [IDX_W-1:0] shift_col(logic [IDX_W-1:0] win, logic top,
                                                  logic mid, logic bot);
      logic [IDX_W-1:0] r;
      r    = (win << 1) & KEEP_MASK;
      r[6] = top;
      r[3] = mid;
      r[0] = bot;
      return r;
   endfunction

endpackage

@@ sv/blnf_chan_if.sv @@
// Handshake channel interfaces: pixel input, filtered result, table writes.
interface blnf_req_if;
   logic valid;
   logic ready;
   logic pixel_in;
   logic row_end;
   logic in_last_row;
   modport source (output valid, pixel_in, row_end, in_last_row, input ready);
   modport sink   (input valid, pixel_in, row_end, in_last_row, output ready);
endinterface

interface blnf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      pixel_out;
   logic [blnf_pkg::ROW_W-1:0] out_row;
   logic [blnf_pkg::COL_W-1:0] out_col;
   logic                      last;
   modport source (output valid, pixel_out, out_row, out_col, last, input ready);
   modport sink   (input valid, pixel_out, out_row, out_col, last, output ready);
endinterface

interface blnf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [blnf_pkg::CSR_IDX_W-1:0] index;
   logic [blnf_pkg::WORD_W-1:0]    wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ sv/binary_neighbourhood_lut_filter_unit.sv @@
// Binary 3x3 neighborhood table filter over a raster stream of 1-bit pixels.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    pixel_in, row_end, in_last_row
//   rsp_if   out  valid/ready    pixel_out, out_row, out_col, last
//   csr_if   in   valid/ready    index (table word 0..7), wdata (64 bits)
//
// One pixel item per cycle while req_if.ready is high; results appear the cycle
// after the item is taken. An item yields 0..4 results, drained from a 4-entry
// result buffer at one per cycle while rsp_if.ready is high; req_if.ready is
// high while that buffer is empty or emptying now.
// Synchronous reset clears the table, counters, window and buffer occupancy; the line
// store needs no clearing (it is always written before it is read).
// csr_if is always ready; write it only while the filter is idle.
`include "binary_neighbourhood_lut_filter_unit_assert.svh"

module binary_neighbourhood_lut_filter_unit (
   input logic        clock,
   input logic        reset,
   blnf_req_if.sink   req_if,
   blnf_rsp_if.source rsp_if,
   blnf_csr_if.sink   csr_if
);

   // ---------------- table registers ----------------
   logic [blnf_pkg::WORD_W-1:0] lut_ff [blnf_pkg::LUT_WORDS];
   blnf_pkg::lut_type           lut_flat;
   logic                        csr_hit;

   assign csr_if.ready = 1'b1;
   assign csr_hit      = csr_if.valid
                         && (csr_if.index < blnf_pkg::CSR_IDX_W'(blnf_pkg::LUT_WORDS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < blnf_pkg::LUT_WORDS; w++) lut_ff[w] <= '0;
      end else if (csr_hit) begin
         lut_ff[csr_if.index[$clog2(blnf_pkg::LUT_WORDS)-1:0]] <= csr_if.wdata;
      end
   end

   always_comb begin
      for (int w = 0; w < blnf_pkg::LUT_WORDS; w++)
         lut_flat[w*blnf_pkg::WORD_W +: blnf_pkg::WORD_W] = lut_ff[w];
   end

   // ---------------- frame state ----------------
   logic [blnf_pkg::IDX_W-1:0] window_ff, window_in;
   logic [blnf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [blnf_pkg::COL_W-1:0] col_ff, col_in;
   logic [blnf_pkg::COL_W:0]   width_ff, width_in;   // previous row width, 0 = none
   logic                       outside_ff, outside_in;

   // line store: bit 1 is row r-1, bit 0 is row r; read data registered
   logic [1:0]                 line_mem [blnf_pkg::MAX_WIDTH];
   logic [1:0]                 rd_ff;
   logic [blnf_pkg::COL_W-1:0] rd_addr;
   logic [1:0]                 wr_data;

   // ---------------- result buffer ----------------
   blnf_pkg::res_type              res_ff [blnf_pkg::NUM_RES];
   blnf_pkg::res_type              res_in [blnf_pkg::NUM_RES];
   logic [blnf_pkg::RES_CNT_W-1:0] left_ff, left_in;
   logic [blnf_pkg::RES_IDX_W-1:0] pos_ff, pos_in;
   logic [blnf_pkg::RES_CNT_W-1:0] n_res;

   logic accept, rsp_take;

   assign rsp_take     = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = (left_ff == '0)
                         || ((left_ff == blnf_pkg::RES_CNT_W'(1)) && rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   // ---------------- per-pixel datapath ----------------
   logic                       o, have_prev, above_ok, top, mid, pix, fin_row, fin_frame;
   logic [blnf_pkg::IDX_W-1:0] win_base, win, fin;
   logic [blnf_pkg::ROW_W-1:0] prow;
   logic [blnf_pkg::COL_W-1:0] c, cm1;
   blnf_pkg::res_type          slot [blnf_pkg::NUM_RES];
   logic [blnf_pkg::NUM_RES-1:0] slot_en;

   always_comb begin
      c         = col_ff;
      cm1       = c - blnf_pkg::COL_W'(1);
      o         = outside_ff;
      pix       = req_if.pixel_in;
      fin_row   = req_if.row_end;
      fin_frame = req_if.row_end && req_if.in_last_row;
      have_prev = (width_ff != '0);
      above_ok  = have_prev && ({1'b0, c} < width_ff);
      prow      = row_ff - blnf_pkg::ROW_W'(1);

      // a new row starts with the outside value in every window bit
      win_base = (c == '0) ? {blnf_pkg::IDX_W{o}} : window_ff;
      top      = above_ok ? rd_ff[1] : o;
      mid      = above_ok ? rd_ff[0] : o;
      wr_data  = {mid, pix};
      win      = blnf_pkg::shift_col(win_base, top, mid, pix);
      fin      = blnf_pkg::shift_col(win, o, o, o);   // past the row end

      // candidate results in emission order
      slot_en[0] = have_prev && (c != '0);
      slot[0]    = '{pixel_out: blnf_pkg::tbl_bit(lut_flat, win),
                     out_row: prow, out_col: cm1, last: 1'b0};
      slot_en[1] = have_prev && fin_row;
      slot[1]    = '{pixel_out: blnf_pkg::tbl_bit(lut_flat, fin),
                     out_row: prow, out_col: c, last: 1'b0};
      // last-row pixels: the row below is outside the frame
      slot_en[2] = req_if.in_last_row && (c != '0);
      slot[2]    = '{pixel_out: blnf_pkg::tbl_bit(lut_flat, {win[5:0], {3{o}}}),
                     out_row: row_ff, out_col: cm1, last: 1'b0};
      slot_en[3] = req_if.in_last_row && fin_row;
      slot[3]    = '{pixel_out: blnf_pkg::tbl_bit(lut_flat, {fin[5:0], {3{o}}}),
                     out_row: row_ff, out_col: c, last: 1'b0};

      // pack enabled slots to the front of the buffer
      n_res = '0;
      for (int k = 0; k < blnf_pkg::NUM_RES; k++) res_in[k] = slot[k];
      for (int k = 0; k < blnf_pkg::NUM_RES; k++) begin
         if (slot_en[k]) begin
            res_in[n_res[blnf_pkg::RES_IDX_W-1:0]] = slot[k];
            n_res = n_res + blnf_pkg::RES_CNT_W'(1);
         end
      end
      for (int k = 0; k < blnf_pkg::NUM_RES; k++)
         res_in[k].last = (blnf_pkg::RES_CNT_W'(k) == n_res - blnf_pkg::RES_CNT_W'(1));

      // state update
      window_in  = window_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      width_in   = width_ff;
      outside_in = outside_ff;
      if (accept) begin
         window_in = win;
         if (fin_frame) begin
            // outside value follows the table's all-dark or all-lit entry
            outside_in = blnf_pkg::tbl_bit(lut_flat, {blnf_pkg::IDX_W{o}});
            window_in  = '0;
            row_in     = '0;
            col_in     = '0;
            width_in   = '0;
         end else if (fin_row) begin
            width_in = {1'b0, c} + (blnf_pkg::COL_W+1)'(1);
            row_in   = row_ff + blnf_pkg::ROW_W'(1);
            col_in   = '0;
         end else begin
            col_in = c + blnf_pkg::COL_W'(1);
         end
      end

      // buffer bookkeeping
      left_in = left_ff;
      pos_in  = pos_ff;
      if (accept) begin
         left_in = n_res;
         pos_in  = '0;
      end else if (rsp_take) begin
         left_in = left_ff - blnf_pkg::RES_CNT_W'(1);
         pos_in  = pos_ff + blnf_pkg::RES_IDX_W'(1);
      end
   end

   assign rd_addr = reset ? '0 : col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         width_ff   <= '0;
         outside_ff <= 1'b0;
         left_ff    <= '0;
         pos_ff     <= '0;
      end else begin
         window_ff  <= window_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         width_ff   <= width_in;
         outside_ff <= outside_in;
         left_ff    <= left_in;
         pos_ff     <= pos_in;
      end
   end

   // line store write at the current column, read ahead at the next one
   always_ff @(posedge clock) begin
      if (accept) line_mem[c] <= wr_data;
      if (accept && (c == rd_addr)) rd_ff <= wr_data;
      else                          rd_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < blnf_pkg::NUM_RES; k++) res_ff[k] <= res_in[k];
      end
   end

   assign rsp_if.valid     = (left_ff != '0);
   assign rsp_if.pixel_out = res_ff[pos_ff].pixel_out;
   assign rsp_if.out_row   = res_ff[pos_ff].out_row;
   assign rsp_if.out_col   = res_ff[pos_ff].out_col;
   assign rsp_if.last      = res_ff[pos_ff].last;

   // ---------------- assertions ----------------
   `BLNF_ASSERT(a_buf_bound, clock, reset,
      ({1'b0, pos_ff} + left_ff) <= blnf_pkg::RES_CNT_W'(blnf_pkg::NUM_RES))
   `BLNF_ASSERT_IMPL(a_last_final, clock, reset, rsp_if.valid && rsp_if.last,
      left_ff == blnf_pkg::RES_CNT_W'(1))
   `BLNF_ASSERT_NEXT(a_frame_clear, clock, reset,
      accept && req_if.row_end && req_if.in_last_row,
      row_ff == '0 && col_ff == '0 && width_ff == '0 && window_ff == '0)
   `BLNF_ASSERT_NEXT(a_drain_stop, clock, reset,
      rsp_take && left_ff == blnf_pkg::RES_CNT_W'(1) && !accept, !rsp_if.valid)

endmodule
